/* design/bfs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfs_pkg
// Shared widths, constants and state encoding for the breadth-first search.
// ----------------------------------------------------------------------------
package bfs_pkg;
  localparam int MaxNodes  = 64;
  localparam int MaxEdges  = 256;
  localparam int NodeW     = $clog2(MaxNodes);
  localparam int CntW      = NodeW + 1;
  localparam int EdgeAw    = $clog2(MaxEdges);
  localparam int EdgeCntW  = EdgeAw + 1;
  localparam int EdgeW     = 2 * NodeW;

  typedef enum logic [2:0] {
    StIdle,
    StDeq,
    StDeqWait,
    StDeqTab,
    StScan,
    StEmitRd,
    StEmit
  } state_e;
endpackage
`default_nettype wire

/* design/bfs_distance_parent.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfs_distance_parent
// Breadth-first search from node 0 over a streamed undirected graph.
// ----------------------------------------------------------------------------
// An edge word is taken whenever start_i is high and busy_o is low. The word with
// last_edge_i set starts the search: busy_o rises and each dequeued node scans
// the whole edge store, one stored edge per cycle from the edge memory read
// port. Then one result per node in use appears, each on the ports for a single
// cycle with result_valid_o; the receiver cannot stall, so it must take every
// strobed word. The edge store is then emptied.
module bfs_distance_parent (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [bfs_pkg::CntW-1:0]    cfg_wdata_i,
  input  wire logic                        start_i,
  output logic                             busy_o,
  input  wire logic                        edge_present_i,
  input  wire logic [bfs_pkg::NodeW-1:0]   end_a_i,
  input  wire logic [bfs_pkg::NodeW-1:0]   end_b_i,
  input  wire logic                        last_edge_i,
  output logic                             result_valid_o,
  output logic      [bfs_pkg::NodeW-1:0]   node_id_o,
  output logic                             reached_o,
  output logic      [bfs_pkg::NodeW-1:0]   hop_distance_o,
  output logic      [bfs_pkg::NodeW-1:0]   parent_node_o,
  output logic                             edges_dropped_o,
  output logic                             last_result_o
);
  localparam int NW = bfs_pkg::NodeW;

  bfs_pkg::state_e state_q, state_d;
  logic [bfs_pkg::CntW-1:0]     node_count_q;
  logic [bfs_pkg::EdgeCntW-1:0] stored_q, stored_d;
  logic                         ovf_q, ovf_d;
  logic [bfs_pkg::MaxNodes-1:0] visited_q, visited_d;
  logic [bfs_pkg::CntW-1:0]     head_q, head_d, tail_q, tail_d;
  logic [bfs_pkg::EdgeCntW-1:0] scan_q, scan_d;
  logic                         scan_vld_q, scan_vld_d;
  logic [NW-1:0]                cur_q, cur_d;
  logic [NW-1:0]                cur_dist_q, cur_dist_d;
  logic [NW-1:0]                emit_q, emit_d;

  logic [NW-1:0] queue_mem [bfs_pkg::MaxNodes];
  logic [NW-1:0] dist_mem  [bfs_pkg::MaxNodes];
  logic [NW-1:0] par_mem   [bfs_pkg::MaxNodes];
  logic [NW-1:0] queue_rd_q, dist_rd_q, par_rd_q;

  logic [bfs_pkg::CntW-1:0] n_use;
  logic                     accept, edge_ok;
  logic [bfs_pkg::EdgeW-1:0] edge_rd;
  logic [NW-1:0]            ea, eb, disc_node;
  logic                     disc;
  logic                     qwe, twe;
  logic [NW-1:0]            qw_addr, qw_data, tw_addr, tw_dist, tw_par;
  logic [NW-1:0]            dist_raddr;
  logic [NW-1:0]            tab_raddr;

  always_comb begin
    if (node_count_q == '0) n_use = bfs_pkg::CntW'(1);
    else if (node_count_q > bfs_pkg::CntW'(bfs_pkg::MaxNodes))
      n_use = bfs_pkg::CntW'(bfs_pkg::MaxNodes);
    else n_use = node_count_q;
  end

  assign busy_o  = (state_q != bfs_pkg::StIdle);
  assign accept  = start_i && !busy_o;
  assign edge_ok = accept && edge_present_i &&
                   ({1'b0, end_a_i} < n_use) && ({1'b0, end_b_i} < n_use);

  bfs_edge_mem u_edge_mem (
    .clk_i   (clk_i),
    .we_i    (edge_ok && (stored_q < bfs_pkg::EdgeCntW'(bfs_pkg::MaxEdges))),
    .waddr_i (stored_q[bfs_pkg::EdgeAw-1:0]),
    .wdata_i ({end_b_i, end_a_i}),
    .raddr_i (scan_q[bfs_pkg::EdgeAw-1:0]),
    .rdata_o (edge_rd)
  );

  assign ea = edge_rd[NW-1:0];
  assign eb = edge_rd[bfs_pkg::EdgeW-1:NW];

  // One discovery per edge at most: a endpoint first, b is then cur itself.
  always_comb begin
    disc      = 1'b0;
    disc_node = ea;
    if (state_q == bfs_pkg::StScan && scan_vld_q &&
        tail_q < bfs_pkg::CntW'(bfs_pkg::MaxNodes)) begin
      if (ea == cur_q && !visited_q[eb]) begin
        disc = 1'b1; disc_node = eb;
      end else if (eb == cur_q && !visited_q[ea]) begin
        disc = 1'b1; disc_node = ea;
      end
    end
  end

  always_comb begin
    state_d    = state_q;
    stored_d   = stored_q;
    ovf_d      = ovf_q;
    visited_d  = visited_q;
    head_d     = head_q;
    tail_d     = tail_q;
    scan_d     = scan_q;
    scan_vld_d = 1'b0;
    cur_d      = cur_q;
    cur_dist_d = cur_dist_q;
    emit_d     = emit_q;
    qwe = 1'b0; qw_addr = tail_q[NW-1:0]; qw_data = disc_node;
    twe = 1'b0; tw_addr = disc_node; tw_dist = cur_dist_q + NW'(1); tw_par = cur_q;
    case (state_q)
      bfs_pkg::StIdle: begin
        if (edge_ok) begin
          if (stored_q < bfs_pkg::EdgeCntW'(bfs_pkg::MaxEdges))
            stored_d = stored_q + bfs_pkg::EdgeCntW'(1);
          else ovf_d = 1'b1;
        end
        if (accept && last_edge_i) begin
          visited_d    = '0;
          visited_d[0] = 1'b1;
          head_d       = '0;
          tail_d       = bfs_pkg::CntW'(1);
          qwe = 1'b1; qw_addr = '0; qw_data = '0;
          twe = 1'b1; tw_addr = '0; tw_dist = '0; tw_par = '0;
          state_d      = bfs_pkg::StDeq;
        end
      end
      bfs_pkg::StDeq: begin
        if (head_q < tail_q) begin
          state_d = bfs_pkg::StDeqWait;
        end else begin
          emit_d  = '0;
          state_d = bfs_pkg::StEmitRd;
        end
      end
      bfs_pkg::StDeqWait: begin
        cur_d      = queue_rd_q;
        head_d     = head_q + bfs_pkg::CntW'(1);
        state_d    = bfs_pkg::StDeqTab;
      end
      bfs_pkg::StDeqTab: begin
        cur_dist_d = dist_rd_q;
        scan_d     = '0;
        state_d    = bfs_pkg::StScan;
      end
      bfs_pkg::StScan: begin
        if (disc) begin
          visited_d[disc_node] = 1'b1;
          tail_d = tail_q + bfs_pkg::CntW'(1);
          qwe = 1'b1;
          twe = 1'b1;
        end
        if (scan_q < stored_q) begin
          scan_vld_d = 1'b1;
          scan_d     = scan_q + bfs_pkg::EdgeCntW'(1);
        end else if (!scan_vld_q) begin
          state_d = bfs_pkg::StDeq;
        end
      end
      bfs_pkg::StEmitRd: state_d = bfs_pkg::StEmit;
      bfs_pkg::StEmit: begin
        if ({1'b0, emit_q} + bfs_pkg::CntW'(1) == n_use) begin
          stored_d = '0;
          ovf_d    = 1'b0;
          state_d  = bfs_pkg::StIdle;
        end else begin
          emit_d  = emit_q + NW'(1);
          state_d = bfs_pkg::StEmitRd;
        end
      end
      default: state_d = bfs_pkg::StIdle;
    endcase
  end

  assign dist_raddr = queue_rd_q;
  assign tab_raddr  = (state_q == bfs_pkg::StEmitRd) ? emit_q : dist_raddr;

  always_ff @(posedge clk_i) begin
    if (qwe) queue_mem[qw_addr] <= qw_data;
    if (twe) begin
      dist_mem[tw_addr] <= tw_dist;
      par_mem[tw_addr]  <= tw_par;
    end
    queue_rd_q <= queue_mem[head_q[NW-1:0]];
  end

  // Dequeue: queue word lands in StDeqWait and addresses the tables; the
  // distance of the dequeued node is taken in StDeqTab.
  always_ff @(posedge clk_i) begin
    dist_rd_q <= dist_mem[tab_raddr];
    par_rd_q  <= par_mem[tab_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= bfs_pkg::StIdle;
      node_count_q <= bfs_pkg::CntW'(bfs_pkg::MaxNodes);
      stored_q     <= '0;
      ovf_q        <= 1'b0;
      visited_q    <= '0;
      head_q       <= '0;
      tail_q       <= '0;
      scan_q       <= '0;
      scan_vld_q   <= 1'b0;
      cur_q        <= '0;
      cur_dist_q   <= '0;
      emit_q       <= '0;
    end else begin
      state_q      <= state_d;
      if (cfg_we_i) node_count_q <= cfg_wdata_i;
      stored_q     <= stored_d;
      ovf_q        <= ovf_d;
      visited_q    <= visited_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
      scan_q       <= scan_d;
      scan_vld_q   <= scan_vld_d;
      cur_q        <= cur_d;
      cur_dist_q   <= cur_dist_d;
      emit_q       <= emit_d;
    end
  end

  always_comb begin
    result_valid_o  = (state_q == bfs_pkg::StEmit);
    node_id_o       = emit_q;
    reached_o       = visited_q[emit_q];
    hop_distance_o  = visited_q[emit_q] ? dist_rd_q : '0;
    parent_node_o   = visited_q[emit_q] ? par_rd_q : '0;
    edges_dropped_o = ovf_q;
    last_result_o   = ({1'b0, emit_q} + bfs_pkg::CntW'(1) == n_use);
  end
endmodule
`default_nettype wire

/* design/bfs_edge_mem.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfs_edge_mem
// Edge store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bfs_edge_mem (
  input  wire logic                        clk_i,
  input  wire logic                        we_i,
  input  wire logic [bfs_pkg::EdgeAw-1:0]  waddr_i,
  input  wire logic [bfs_pkg::EdgeW-1:0]   wdata_i,
  input  wire logic [bfs_pkg::EdgeAw-1:0]  raddr_i,
  output logic      [bfs_pkg::EdgeW-1:0]   rdata_o
);
  logic [bfs_pkg::EdgeW-1:0] mem_q [bfs_pkg::MaxEdges];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Streams graphs into bfs_distance_parent and checks every per-node word
// against a breadth-first search computed here from the accepted edges.
// ----------------------------------------------------------------------------
module tb_top;
  localparam int WatchLimit = 100000;

  typedef struct packed {
    logic [bfs_pkg::NodeW-1:0] node_id;
    logic                      reached;
    logic [bfs_pkg::NodeW-1:0] hop_distance;
    logic [bfs_pkg::NodeW-1:0] parent_node;
    logic                      edges_dropped;
    logic                      last_result;
  } node_word_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        cfg_we_i = 1'b0;
  logic [bfs_pkg::CntW-1:0]    cfg_wdata_i = '0;
  logic                        start_i = 1'b0;
  logic                        busy_o;
  logic                        edge_present_i = 1'b0;
  logic [bfs_pkg::NodeW-1:0]   end_a_i = '0;
  logic [bfs_pkg::NodeW-1:0]   end_b_i = '0;
  logic                        last_edge_i = 1'b0;
  logic                        result_valid_o;
  logic [bfs_pkg::NodeW-1:0]   node_id_o;
  logic                        reached_o;
  logic [bfs_pkg::NodeW-1:0]   hop_distance_o;
  logic [bfs_pkg::NodeW-1:0]   parent_node_o;
  logic                        edges_dropped_o;
  logic                        last_result_o;

  bfs_distance_parent dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .start_i(start_i), .busy_o(busy_o), .edge_present_i(edge_present_i),
    .end_a_i(end_a_i), .end_b_i(end_b_i), .last_edge_i(last_edge_i),
    .result_valid_o(result_valid_o), .node_id_o(node_id_o), .reached_o(reached_o),
    .hop_distance_o(hop_distance_o), .parent_node_o(parent_node_o),
    .edges_dropped_o(edges_dropped_o), .last_result_o(last_result_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  node_word_t                 node_words_q[$];
  logic [bfs_pkg::CntW-1:0]   shadow_count = 7'd64;
  logic [bfs_pkg::EdgeW-1:0]  edge_mem[bfs_pkg::MaxEdges];
  int                         edge_total = 0;
  bit                         dropped_seen = 1'b0;
  int                         mismatches = 0;
  int                         idle_pct = 0;
  int                         quiet_cycles = 0;

  function automatic int nodes_active();
    int n;
    n = shadow_count;
    if (n == 0) n = 1;
    if (n > bfs_pkg::MaxNodes) n = bfs_pkg::MaxNodes;
    return n;
  endfunction

  // walk the stored edges and queue the per-node words
  function automatic void predict_search();
    bit   seen[bfs_pkg::MaxNodes];
    int   hops[bfs_pkg::MaxNodes];
    int   par[bfs_pkg::MaxNodes];
    int   fifo[bfs_pkg::MaxNodes];
    int   head, tail, n, cur, ea, eb;
    node_word_t w;
    n = nodes_active();
    for (int i = 0; i < bfs_pkg::MaxNodes; i++) seen[i] = 1'b0;
    seen[0] = 1'b1; hops[0] = 0; par[0] = 0; fifo[0] = 0;
    head = 0; tail = 1;
    while (head < tail) begin
      cur = fifo[head];
      head++;
      for (int e = 0; e < edge_total; e++) begin
        ea = edge_mem[e][bfs_pkg::NodeW-1:0];
        eb = edge_mem[e][bfs_pkg::EdgeW-1:bfs_pkg::NodeW];
        if (ea == cur && !seen[eb]) begin
          seen[eb] = 1'b1; hops[eb] = (hops[cur] + 1) % 64; par[eb] = cur;
          fifo[tail] = eb; tail++;
        end
        if (eb == cur && !seen[ea]) begin
          seen[ea] = 1'b1; hops[ea] = (hops[cur] + 1) % 64; par[ea] = cur;
          fifo[tail] = ea; tail++;
        end
      end
    end
    for (int k = 0; k < n; k++) begin
      w.node_id       = bfs_pkg::NodeW'(k);
      w.reached       = seen[k];
      w.hop_distance  = seen[k] ? bfs_pkg::NodeW'(hops[k]) : '0;
      w.parent_node   = seen[k] ? bfs_pkg::NodeW'(par[k]) : '0;
      w.edges_dropped = dropped_seen;
      w.last_result   = (k == n - 1);
      node_words_q    = {node_words_q, w};
    end
    edge_total   = 0;
    dropped_seen = 1'b0;
  endfunction

  function automatic void predict_word(bit ep, int a, int b, bit last);
    int n;
    n = nodes_active();
    if (ep && a < n && b < n) begin
      if (edge_total < bfs_pkg::MaxEdges) begin
        edge_mem[edge_total] = {b[bfs_pkg::NodeW-1:0], a[bfs_pkg::NodeW-1:0]};
        edge_total++;
      end else begin
        dropped_seen = 1'b1;
      end
    end
    if (last) predict_search();
  endfunction

  // called and returns at a falling edge
  task automatic send_word(bit ep, int a, int b, bit last);
    if ($urandom_range(99) < idle_pct) begin
      start_i = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    start_i = 1'b1;
    edge_present_i = ep;
    end_a_i = bfs_pkg::NodeW'(a);
    end_b_i = bfs_pkg::NodeW'(b);
    last_edge_i = last;
    forever begin
      @(posedge clk_i);
      if (!busy_o) break;
    end
    predict_word(ep, a, b, last);
    @(negedge clk_i);
    start_i = 1'b0;
    edge_present_i = 1'($urandom_range(1));
    end_a_i = bfs_pkg::NodeW'($urandom);
    end_b_i = bfs_pkg::NodeW'($urandom);
    last_edge_i = 1'($urandom_range(1));
  endtask

  task automatic drain();
    while (node_words_q.size() != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
  endtask

  task automatic write_count(int v);
    drain();
    cfg_we_i = 1'b1;
    cfg_wdata_i = bfs_pkg::CntW'(v);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    cfg_wdata_i = bfs_pkg::CntW'($urandom);
    shadow_count = bfs_pkg::CntW'(v);
  endtask

  task automatic send_graph(int edges);
    int n, a, b, r;
    n = nodes_active();
    for (int i = 0; i < edges; i++) begin
      r = $urandom_range(99);
      a = $urandom_range(n - 1);
      b = $urandom_range(n - 1);
      if (r < 5) send_word(1'b0, $urandom_range(63), $urandom_range(63), 1'b0);
      else if (r < 12 && n < bfs_pkg::MaxNodes)
        send_word(1'b1, $urandom_range(63, n), b, 1'b0);
      else if (r < 16 && n < bfs_pkg::MaxNodes)
        send_word(1'b1, a, $urandom_range(63, n), 1'b0);
      else send_word(1'b1, a, b, 1'b0);
    end
    if ($urandom_range(1))
      send_word(1'b1, $urandom_range(n - 1), $urandom_range(n - 1), 1'b1);
    else send_word(1'b0, $urandom_range(63), $urandom_range(63), 1'b1);
  endtask

  task automatic test_directed();
    send_word(1'b0, 0, 0, 1'b1);
    send_word(1'b1, 0, 63, 1'b0);
    send_word(1'b1, 63, 63, 1'b0);
    send_word(1'b1, 63, 0, 1'b0);
    send_word(1'b0, 5, 6, 1'b0);
    send_word(1'b1, 63, 31, 1'b0);
    send_word(1'b1, 42, 21, 1'b1);
    write_count(5);
    send_word(1'b1, 4, 0, 1'b0);
    send_word(1'b1, 63, 1, 1'b0);
    send_word(1'b1, 2, 5, 1'b0);
    send_word(1'b1, 4, 3, 1'b0);
    send_word(1'b1, 1, 0, 1'b1);
    write_count(0);
    send_word(1'b1, 0, 0, 1'b1);
    send_word(1'b1, 1, 0, 1'b1);
    write_count(127);
    send_word(1'b1, 63, 62, 1'b0);
    send_word(1'b1, 0, 62, 1'b1);
    write_count(2);
    send_word(1'b1, 1, 0, 1'b1);
  endtask

  task automatic test_overflow();
    write_count(8);
    for (int i = 0; i < bfs_pkg::MaxEdges + 4; i++)
      send_word(1'b1, $urandom_range(7), $urandom_range(7), 1'b0);
    send_word(1'b0, 0, 0, 1'b1);
    send_graph(3);
  endtask

  task automatic test_random(int pct, int graphs);
    idle_pct = pct;
    for (int g = 0; g < graphs; g++) begin
      if ($urandom_range(3) == 0) write_count($urandom_range(1, 64));
      else if ($urandom_range(7) == 0) write_count(64);
      send_graph($urandom_range(0, 12));
      if (g == graphs / 2) drain();
    end
  endtask

  always @(posedge clk_i) begin
    node_word_t got, want;
    if (result_valid_o) begin
      got = {node_id_o, reached_o, hop_distance_o, parent_node_o,
             edges_dropped_o, last_result_o};
      if (node_words_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: node %0d", node_id_o);
      end else begin
        want = node_words_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("word mismatch: exp id=%0d r=%0d d=%0d p=%0d f=%0d l=%0d",
                     want.node_id, want.reached, want.hop_distance, want.parent_node,
                     want.edges_dropped, want.last_result);
            $display("               got id=%0d r=%0d d=%0d p=%0d f=%0d l=%0d",
                     got.node_id, got.reached, got.hop_distance, got.parent_node,
                     got.edges_dropped, got.last_result);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || result_valid_o || !rst_ni) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_overflow();
    test_random(0, 2);
    test_random(72, 2);
    test_random(27, 2);
    write_count(64);
    test_random(0, 1);
    drain();
    repeat (100) @(negedge clk_i);
    if (mismatches == 0 && node_words_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
